@@ sv/vbhb_pkg.sv @@
// Shared constants, types and helpers of the veto bar hit builder.
`default_nettype none

package vbhb_pkg;

	localparam int CHANNEL_COUNT = 32;
	localparam int TIME_BITS     = 16;

	localparam int CH_W          = $clog2(CHANNEL_COUNT);
	localparam int CHAN_FIELD_W  = 5;
	localparam int FIELD_TIME_W  = 16;

	localparam int REG_W         = 5;
	localparam int REG_COUNT     = 7;
	localparam int REG_IDX_W     = 3;

	localparam int BAR_W         = 2;
	localparam int HITNUM_W      = 2;
	localparam int TOF_W         = 18;
	localparam int CHARGE_W      = 20;
	localparam int TDIFF_W       = 17;

	localparam int MAX_RESULTS   = 3;
	localparam int RES_IDX_W     = 2;

	localparam int W_W           = TIME_BITS + 1;
	localparam int PROD_W        = 2 * TIME_BITS;
	localparam int Q_FRAC        = 4;
	localparam int RAD_W         = PROD_W + 2 * Q_FRAC;
	localparam int ROOT_W        = RAD_W / 2;
	localparam int SQRT_CNT_W    = $clog2(ROOT_W + 1);
	localparam int CALC_W        = (TIME_BITS + 3 > 20) ? TIME_BITS + 3 : 20;
	localparam int ROOTX_W       = (ROOT_W > CHARGE_W) ? ROOT_W : CHARGE_W;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TOP_LEFT     = 3'd0,
		REG_TOP_RIGHT    = 3'd1,
		REG_MID_LEFT     = 3'd2,
		REG_MID_RIGHT    = 3'd3,
		REG_BOTTOM_LEFT  = 3'd4,
		REG_BOTTOM_RIGHT = 3'd5,
		REG_TRIGGER      = 3'd6
	} reg_idx_t;

	typedef enum logic {
		OP_HIT   = 1'b0,
		OP_CLOSE = 1'b1
	} op_t;

	typedef enum logic [BAR_W-1:0] {
		BAR_TOP    = 2'd0,
		BAR_MID    = 2'd1,
		BAR_BOTTOM = 2'd2,
		BAR_NONE   = 2'd3
	} bar_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TRIG,
		S_LEFT,
		S_RIGHT,
		S_MUL,
		S_PROD,
		S_SQRT,
		S_EMIT
	} state_t;

	typedef struct packed {
		bar_t                       bar;
		logic signed [TOF_W-1:0]    tof;
		logic        [CHARGE_W-1:0] charge;
		logic signed [TDIFF_W-1:0]  tdiff;
	} result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_stat_t;

	function automatic logic chan_ok(input logic [CHAN_FIELD_W-1:0] c);
		logic [CHAN_FIELD_W+CH_W-1:0] wide;
		wide = {{CH_W{1'b0}}, c};
		return wide < (CHAN_FIELD_W + CH_W)'(CHANNEL_COUNT);
	endfunction

	function automatic logic [CH_W-1:0] chan_idx(input logic [CHAN_FIELD_W-1:0] c);
		logic [CHAN_FIELD_W+CH_W-1:0] wide;
		wide = {{CH_W{1'b0}}, c};
		return wide[CH_W-1:0];
	endfunction

	function automatic logic [TIME_BITS-1:0] time_fit(input logic [FIELD_TIME_W-1:0] t);
		logic [FIELD_TIME_W+TIME_BITS-1:0] wide;
		wide = {{TIME_BITS{1'b0}}, t};
		return wide[TIME_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

@@ sv/vbhb_hit_if.sv @@
// Input channel carrying hit and close-event items.
`default_nettype none

interface vbhb_hit_if import vbhb_pkg::*; ();
	logic                    valid;
	logic                    ready;
	op_t                     opcode;
	logic [CHAN_FIELD_W-1:0] channel;
	logic [FIELD_TIME_W-1:0] leading_time;
	logic [FIELD_TIME_W-1:0] trailing_time;

	modport source (output valid, opcode, channel, leading_time, trailing_time, input ready);
	modport sink (input valid, opcode, channel, leading_time, trailing_time, output ready);
endinterface

`default_nettype wire

@@ sv/vbhb_res_if.sv @@
// Output channel carrying bar results.
`default_nettype none

interface vbhb_res_if import vbhb_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic        [BAR_W-1:0]    bar;
	logic        [HITNUM_W-1:0] hit_number;
	logic signed [TOF_W-1:0]    flight_time_half;
	logic        [CHARGE_W-1:0] charge_q4;
	logic signed [TDIFF_W-1:0]  time_difference;
	logic                       last;

	modport source (output valid, bar, hit_number, flight_time_half, charge_q4,
		time_difference, last, input ready);
	modport sink (input valid, bar, hit_number, flight_time_half, charge_q4,
		time_difference, last, output ready);
endinterface

`default_nettype wire

@@ sv/vbhb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module vbhb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ sv/vbhb_sqrt.sv @@
// Iterative floor square root, one result bit per cycle.
`default_nettype none

module vbhb_sqrt import vbhb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [RAD_W-1:0]  radicand,
	output logic      [ROOT_W-1:0] root,
	output sqrt_stat_t             stat
);

	logic [RAD_W-1:0]      rad_q;
	logic [ROOT_W:0]       rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [ROOT_W+1:0]     rem_sh;
	logic [ROOT_W+1:0]     trial;
	logic [ROOT_W+1:0]     diff;
	logic                  ge;

	assign rem_sh = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign diff   = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQRT_CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - SQRT_CNT_W'(1);
				if (cnt_q == SQRT_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

@@ sv/veto_bar_hit_builder_top.sv @@
// Veto bar hit builder top level: hit store, bar sequencer and result buffer.
//
// Channels: hit (sink) takes items; opcode hit records channel, leading and
// trailing time into the hit store and gives no result.
// Opcode close checks the top, middle and bottom bars in turn and then
// delivers one result per firing bar on result (source), or one result with
// bar 3 if none fires; last marks the final result of the event.
// The configuration port (cfg_we, cfg_index, cfg_data) maps the six bar ends
// and the trigger to channels; write it only while the block is idle.
// A close first reads the trigger channel, then for each bar reads and checks
// the store, using the shared square-root unit (one root bit per cycle) when
// the bar fires; results then transfer one per cycle while result.ready is
// high.
// hit.ready is low from close acceptance until the last result transfers.
// A stalled receiver holds the current result; nothing is lost or repeated.
// Reset clears the hit-valid marks and loads the default channel map; the
// hit store itself is not cleared and needs no clearing pass.
`default_nettype none

module veto_bar_hit_builder_top import vbhb_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	vbhb_hit_if.sink                     hit,
	vbhb_res_if.source                   result,
	input  wire logic                    cfg_we,
	input  wire logic [REG_IDX_W-1:0]    cfg_index,
	input  wire logic [REG_W-1:0]        cfg_data
);

	state_t                   state_q, state_d;
	bar_t                     bar_q;
	logic [RES_IDX_W-1:0]     cnt_q;
	logic [RES_IDX_W-1:0]     emit_q;
	logic [CHANNEL_COUNT-1:0] seen_q;
	logic [REG_W-1:0]         cfg_q [REG_COUNT];

	logic                     hit_xfer;
	logic                     res_xfer;
	logic                     store_we;
	logic                     bar_done;
	logic                     sqrt_start;
	logic                     fire;
	logic                     no_bar;
	logic                     res_last;

	logic [REG_W-1:0]         left_ch;
	logic [REG_W-1:0]         right_ch;
	logic [REG_W-1:0]         rd_ch;
	logic [2*TIME_BITS-1:0]   rdata;
	logic                     rvld_s1;
	logic [TIME_BITS-1:0]     r_lead;
	logic [TIME_BITS-1:0]     r_trail;
	logic signed [W_W-1:0]    r_w;

	logic [TIME_BITS-1:0]     trig_q;
	logic [TIME_BITS-1:0]     left_lead_q;
	logic signed [W_W-1:0]    left_w_q;
	logic [TIME_BITS-1:0]     right_lead_q;
	logic signed [W_W-1:0]    right_w_q;
	bar_t                     pend_bar_q;
	logic [TOF_W-1:0]         pend_tof_q;
	logic [TDIFF_W-1:0]       pend_tdiff_q;
	result_t                  res_q [MAX_RESULTS];
	result_t                  cur;

	logic [CALC_W-1:0]        tof_full;
	logic [CALC_W-1:0]        tdiff_full;
	logic [PROD_W-1:0]        prod;
	logic [ROOT_W-1:0]        root;
	logic [ROOTX_W-1:0]       rootx;
	sqrt_stat_t               sqrt_stat;

	assign hit_xfer = hit.valid && hit.ready;
	assign res_xfer = result.valid && result.ready;
	assign store_we = hit_xfer && (hit.opcode == OP_HIT) && chan_ok(hit.channel);

	vbhb_ram #(
		.WIDTH(2 * TIME_BITS),
		.DEPTH(CHANNEL_COUNT)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(chan_idx(hit.channel)),
		.wdata({time_fit(hit.leading_time), time_fit(hit.trailing_time)}),
		.raddr(chan_idx(rd_ch)),
		.rdata(rdata)
	);

	vbhb_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.radicand({prod, {(2 * Q_FRAC){1'b0}}}),
		.root    (root),
		.stat    (sqrt_stat)
	);

	always_comb begin
		unique case (bar_q)
			BAR_TOP: begin
				left_ch  = cfg_q[REG_TOP_LEFT];
				right_ch = cfg_q[REG_TOP_RIGHT];
			end
			BAR_MID: begin
				left_ch  = cfg_q[REG_MID_LEFT];
				right_ch = cfg_q[REG_MID_RIGHT];
			end
			default: begin
				left_ch  = cfg_q[REG_BOTTOM_LEFT];
				right_ch = cfg_q[REG_BOTTOM_RIGHT];
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_LEFT:  rd_ch = left_ch;
			S_RIGHT: rd_ch = right_ch;
			default: rd_ch = cfg_q[REG_TRIGGER];
		endcase
	end

	assign r_lead  = rvld_s1 ? rdata[2*TIME_BITS-1:TIME_BITS] : '0;
	assign r_trail = rvld_s1 ? rdata[TIME_BITS-1:0] : '0;
	assign r_w     = $signed({1'b0, r_trail}) - $signed({1'b0, r_lead});

	assign fire = !left_w_q[W_W-1] && (left_w_q != '0)
		&& !right_w_q[W_W-1] && (right_w_q != '0);

	assign tof_full   = CALC_W'(left_lead_q) + CALC_W'(right_lead_q)
		- (CALC_W'(trig_q) << 1);
	assign tdiff_full = CALC_W'(left_lead_q) - CALC_W'(right_lead_q);
	assign prod       = PROD_W'(left_w_q[TIME_BITS-1:0])
		* PROD_W'(right_w_q[TIME_BITS-1:0]);
	assign rootx      = ROOTX_W'(root);

	always_comb begin
		state_d    = state_q;
		sqrt_start = 1'b0;
		bar_done   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (hit_xfer && hit.opcode == OP_CLOSE) begin
					state_d = S_TRIG;
				end
			end
			S_TRIG:  state_d = S_LEFT;
			S_LEFT:  state_d = S_RIGHT;
			S_RIGHT: state_d = S_MUL;
			S_MUL:   state_d = S_PROD;
			S_PROD: begin
				if (fire) begin
					sqrt_start = 1'b1;
					state_d    = S_SQRT;
				end else begin
					bar_done = 1'b1;
					state_d  = (bar_q == BAR_BOTTOM) ? S_EMIT : S_LEFT;
				end
			end
			S_SQRT: begin
				if (sqrt_stat.done) begin
					bar_done = 1'b1;
					state_d  = (bar_q == BAR_BOTTOM) ? S_EMIT : S_LEFT;
				end
			end
			S_EMIT: begin
				if (res_xfer && res_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_q   <= BAR_TOP;
			cnt_q   <= '0;
			emit_q  <= '0;
			seen_q  <= '0;
			rvld_s1 <= 1'b0;
			for (int i = 0; i < REG_COUNT; i++) begin
				cfg_q[i] <= REG_W'(i);
			end
		end else begin
			rvld_s1 <= chan_ok(rd_ch) && seen_q[chan_idx(rd_ch)];
			if (cfg_we && cfg_index < REG_IDX_W'(REG_COUNT)) begin
				cfg_q[cfg_index] <= cfg_data;
			end
			if (store_we) begin
				seen_q[chan_idx(hit.channel)] <= 1'b1;
			end
			if (state_q == S_IDLE && hit_xfer && hit.opcode == OP_CLOSE) begin
				bar_q  <= BAR_TOP;
				cnt_q  <= '0;
				emit_q <= '0;
			end
			if (bar_done) begin
				bar_q <= bar_t'(BAR_W'(bar_q + 2'd1));
			end
			if (state_q == S_SQRT && sqrt_stat.done) begin
				cnt_q <= cnt_q + RES_IDX_W'(1);
			end
			if (res_xfer) begin
				emit_q <= emit_q + RES_IDX_W'(1);
				if (res_last) begin
					seen_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LEFT && bar_q == BAR_TOP) begin
			trig_q <= r_lead;
		end
		if (state_q == S_RIGHT) begin
			left_lead_q <= r_lead;
			left_w_q    <= r_w;
		end
		if (state_q == S_MUL) begin
			right_lead_q <= r_lead;
			right_w_q    <= r_w;
		end
		if (state_q == S_PROD) begin
			pend_bar_q   <= bar_q;
			pend_tof_q   <= tof_full[TOF_W-1:0];
			pend_tdiff_q <= tdiff_full[TDIFF_W-1:0];
		end
		if (state_q == S_SQRT && sqrt_stat.done) begin
			res_q[cnt_q] <= '{bar: pend_bar_q, tof: pend_tof_q,
				charge: rootx[CHARGE_W-1:0], tdiff: pend_tdiff_q};
		end
	end

	assign cur      = res_q[emit_q];
	assign no_bar   = (cnt_q == '0);
	assign res_last = no_bar || (emit_q == cnt_q - RES_IDX_W'(1));

	assign hit.ready               = (state_q == S_IDLE);
	assign result.valid            = (state_q == S_EMIT);
	assign result.bar              = no_bar ? BAR_NONE : cur.bar;
	assign result.hit_number       = emit_q;
	assign result.flight_time_half = no_bar ? '0 : cur.tof;
	assign result.charge_q4        = no_bar ? '0 : cur.charge;
	assign result.time_difference  = no_bar ? '0 : cur.tdiff;
	assign result.last             = res_last;

	a_mask_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(res_xfer && res_last) |=> (seen_q == '0))
		else $error("hit marks not cleared after final transfer");

	a_sqrt_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_start |-> !sqrt_stat.busy)
		else $error("square root started while busy");

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_stat.busy |-> !hit.ready)
		else $error("input ready during square root");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && cnt_q != '0) |-> (emit_q < cnt_q))
		else $error("result index beyond stored results");

endmodule

`default_nettype wire
